/* src/assert_macros.svh */
// Assertion macros shared by the voxel grid to points modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk outside reset.
`define VGP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, during reset as well.
`define VGP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/vgp_pkg.sv */
// Package with the types and constants of the voxel grid to points block.
package vgp_pkg;

    localparam int CFG_DIM_W       = 11;
    localparam int RES_W           = 24;
    localparam int ORIGIN_W        = 32;
    localparam int POINT_W         = 40;
    localparam int OCC_W           = 8;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int DEFAULT_MAX_DIM = 1024;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic signed [OCC_W-1:0] OCCUPIED_CODE = 8'sd100;
    localparam logic [RES_W-1:0]        RES_RESET     = 24'd65536;
    localparam logic [CFG_DIM_W-1:0]    DIM_RESET     = 11'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH = 3'd0,
        CFG_GRID_DEPTH = 3'd1,
        CFG_RESOLUTION = 3'd2,
        CFG_ORIGIN_X   = 3'd3,
        CFG_ORIGIN_Y   = 3'd4,
        CFG_ORIGIN_Z   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]       grid_width;
        logic [CFG_DIM_W-1:0]       grid_depth;
        logic [RES_W-1:0]           resolution;
        logic signed [ORIGIN_W-1:0] origin_x;
        logic signed [ORIGIN_W-1:0] origin_y;
        logic signed [ORIGIN_W-1:0] origin_z;
    } t_grid_cfg;

    typedef struct packed {
        logic occupied;
        logic last;
    } t_cell_flags;

endpackage

/* src/vgp_if.sv */
// Stream interfaces for grid cells in and voxel centre points out.
interface vgp_cell_if
    import vgp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OCC_W-1:0] occupancy;
    logic                    last_cell;

    modport source (output valid, occupancy, last_cell, input ready);
    modport sink (input valid, occupancy, last_cell, output ready);
endinterface

interface vgp_point_if
    import vgp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;
    logic                      point_valid;
    logic                      grid_end;

    modport source (output valid, point_x, point_y, point_z, point_valid, grid_end,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, point_valid, grid_end,
                  output ready);
endinterface

/* src/vgp_queue.sv */
// Short job queue between the cell front end and the point back end.
`include "assert_macros.svh"

module vgp_queue
    import vgp_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_ready = r_count < CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `VGP_ASSERT(a_queue_bound, (r_count <= CNT_W'(QUEUE_DEPTH)), "Queue count exceeds depth.")
    `VGP_ASSERT(a_queue_push_only, (do_push && !do_pop |=> r_count == $past(r_count) + 1'b1), "Queue count did not grow on a push.")

endmodule

/* src/vgp_front.sv */
// Front end: accepts grid cells, tracks their position and queues result jobs.
`include "assert_macros.svh"

module vgp_front
    import vgp_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM,
    parameter int IDX_W   = $clog2(MAX_DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vgp_cell_if.sink         i_cell,
    input  t_grid_cfg        i_cfg,
    input  logic             i_queue_ready,
    output logic             o_push,
    output logic [IDX_W-1:0] o_column,
    output logic [IDX_W-1:0] o_row,
    output logic [IDX_W-1:0] o_layer,
    output t_cell_flags      o_flags
);
    localparam int CMP_W = (IDX_W + 1 > CFG_DIM_W) ? IDX_W + 1 : CFG_DIM_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    logic [IDX_W-1:0] r_column, n_column;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_layer, n_layer;
    logic [CMP_W-1:0] eff_width, eff_depth;
    logic             accept;
    logic             occupied;

    function automatic logic [CMP_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] dim);
        logic [CMP_W-1:0] d;
        d = CMP_W'(dim);
        if (d == '0) begin
            return CMP_W'(1);
        end else if (d > MAX_DIM_C) begin
            return MAX_DIM_C;
        end
        return d;
    endfunction

    assign i_cell.ready = i_queue_ready;
    assign accept       = i_cell.valid && i_cell.ready;
    assign occupied     = i_cell.occupancy == OCCUPIED_CODE;
    assign eff_width    = eff_dim(i_cfg.grid_width);
    assign eff_depth    = eff_dim(i_cfg.grid_depth);

    assign o_push           = accept && (occupied || i_cell.last_cell);
    assign o_column         = r_column;
    assign o_row            = r_row;
    assign o_layer          = r_layer;
    assign o_flags.occupied = occupied;
    assign o_flags.last     = i_cell.last_cell;

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        n_layer  = r_layer;
        if (accept) begin
            if (i_cell.last_cell) begin
                n_column = '0;
                n_row    = '0;
                n_layer  = '0;
            end else if (CMP_W'(r_column) + 1'b1 >= eff_width) begin
                n_column = '0;
                if (CMP_W'(r_row) + 1'b1 >= eff_depth) begin
                    n_row = '0;
                    if (CMP_W'(r_layer) + 1'b1 < MAX_DIM_C) begin
                        n_layer = r_layer + 1'b1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_column = r_column + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
            r_layer  <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
            r_layer  <= n_layer;
        end
    end

    `VGP_ASSERT(a_last_clears, (accept && i_cell.last_cell |=> r_column == '0 && r_row == '0 && r_layer == '0), "Position not cleared after the last cell.")
    `VGP_ASSERT(a_layer_bound, (CMP_W'(r_layer) < MAX_DIM_C), "Layer index beyond the grid limit.")

endmodule

/* src/vgp_back.sv */
// Back end: computes voxel centres from queued jobs and holds the result item.
`include "assert_macros.svh"

module vgp_back
    import vgp_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM,
    parameter int IDX_W   = $clog2(MAX_DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_grid_cfg        i_cfg,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_column,
    input  logic [IDX_W-1:0] i_row,
    input  logic [IDX_W-1:0] i_layer,
    input  t_cell_flags      i_flags,
    output logic             o_pop,
    vgp_point_if.source      o_point
);
    localparam int PROD_W = RES_W + IDX_W + 1;

    logic              r_s1_valid;
    t_cell_flags       r_s1_flags;
    logic [PROD_W-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic              r_out_valid;
    logic [POINT_W-1:0] r_x, r_y, r_z;
    t_cell_flags       r_out_flags;
    logic              s1_ready, s2_ready, s2_load;

    function automatic logic [PROD_W-1:0] scaled(input logic [RES_W-1:0] res,
                                                 input logic [IDX_W-1:0] idx);
        return PROD_W'(res) * PROD_W'({idx, 1'b1});
    endfunction

    function automatic logic [POINT_W-1:0] centre(input logic [PROD_W-1:0] prod,
                                                  input logic signed [ORIGIN_W-1:0] org);
        return POINT_W'(prod >> 1) + POINT_W'(org);
    endfunction

    assign s2_ready = !r_out_valid || o_point.ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign s2_load  = r_s1_valid && s2_ready;
    assign o_pop    = i_valid && s1_ready;

    assign o_point.valid       = r_out_valid;
    assign o_point.point_x     = $signed(r_x);
    assign o_point.point_y     = $signed(r_y);
    assign o_point.point_z     = $signed(r_z);
    assign o_point.point_valid = r_out_flags.occupied;
    assign o_point.grid_end    = r_out_flags.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_flags <= i_flags;
            r_prod_x   <= scaled(i_cfg.resolution, i_column);
            r_prod_y   <= scaled(i_cfg.resolution, i_row);
            r_prod_z   <= scaled(i_cfg.resolution, i_layer);
        end
        if (s2_load) begin
            r_out_flags <= r_s1_flags;
            if (r_s1_flags.occupied) begin
                r_x <= centre(r_prod_x, i_cfg.origin_x);
                r_y <= centre(r_prod_y, i_cfg.origin_y);
                r_z <= centre(r_prod_z, i_cfg.origin_z);
            end else begin
                r_x <= '0;
                r_y <= '0;
                r_z <= '0;
            end
        end
    end

    `VGP_ASSERT(a_result_kind, (r_out_valid |-> r_out_flags.occupied || r_out_flags.last), "Result item carries neither a point nor an end marker.")
    `VGP_ASSERT(a_empty_marker, (r_out_valid && !r_out_flags.occupied |-> r_x == '0 && r_y == '0 && r_z == '0), "End marker without a point has nonzero coordinates.")

endmodule

/* src/voxel_grid_to_points_top.sv */
// Top level of the voxel grid to points block. It takes the cells of a 3D
// occupancy grid in raster order, x fastest, one cell per item, and returns one
// item per occupied cell carrying the voxel centre in signed Q23.16, plus an
// end marker for the cell flagged last. The block accepts one cell per clock
// cycle while the job queue has room. The cell's job enters the two-entry job
// queue at the accepting edge, then passes the multiply stage and the output
// register. Cells that give no result do not occupy the queue, but like any
// cell they wait while the queue is full. The user must write the registers
// only while no item is in flight; the block itself does not enforce this.
module voxel_grid_to_points_top
    import vgp_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vgp_cell_if.sink              i_cell,
    vgp_point_if.source           o_point,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int JOB_W = 3 * IDX_W + $bits(t_cell_flags);

    t_grid_cfg        r_cfg;
    logic             push, queue_ready, queue_valid, pop;
    logic [IDX_W-1:0] f_column, f_row, f_layer;
    logic [IDX_W-1:0] b_column, b_row, b_layer;
    t_cell_flags      f_flags, b_flags;
    logic [JOB_W-1:0] job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width <= DIM_RESET;
            r_cfg.grid_depth <= DIM_RESET;
            r_cfg.resolution <= RES_RESET;
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.origin_z   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH: r_cfg.grid_width <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_GRID_DEPTH: r_cfg.grid_depth <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_RESOLUTION: r_cfg.resolution <= i_cfg_data[RES_W-1:0];
                CFG_ORIGIN_X:   r_cfg.origin_x   <= $signed(i_cfg_data[ORIGIN_W-1:0]);
                CFG_ORIGIN_Y:   r_cfg.origin_y   <= $signed(i_cfg_data[ORIGIN_W-1:0]);
                CFG_ORIGIN_Z:   r_cfg.origin_z   <= $signed(i_cfg_data[ORIGIN_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    vgp_front #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell        (i_cell),
        .i_cfg         (r_cfg),
        .i_queue_ready (queue_ready),
        .o_push        (push),
        .o_column      (f_column),
        .o_row         (f_row),
        .o_layer       (f_layer),
        .o_flags       (f_flags)
    );

    assign job_in = {f_layer, f_row, f_column, f_flags};
    assign {b_layer, b_row, b_column, b_flags} = job_out;

    vgp_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_data  (job_out),
        .i_pop   (pop)
    );

    vgp_back #(
        .MAX_DIM (MAX_DIM),
        .IDX_W   (IDX_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (queue_valid),
        .i_column (b_column),
        .i_row    (b_row),
        .i_layer  (b_layer),
        .i_flags  (b_flags),
        .o_pop    (pop),
        .o_point  (o_point)
    );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the voxel grid to points block with random flow control.
module tb;
    import vgp_pkg::*;

    localparam int GRID_MAX      = DEFAULT_MAX_DIM;
    localparam int LONG_CELLS    = GRID_MAX + 4;
    localparam int SMALL_CELLS   = 900;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_AT_CELL  = SMALL_CELLS + 400;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400_000;

    typedef struct {
        logic signed [OCC_W-1:0] occupancy;
        logic                    last_cell;
    } t_cell;

    typedef struct {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
        logic signed [POINT_W-1:0] z;
        logic                      point_valid;
        logic                      grid_end;
    } t_voxel_point;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    vgp_cell_if  cell_bus ();
    vgp_point_if point_bus ();

    voxel_grid_to_points_top #(
        .MAX_DIM(GRID_MAX)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (cell_bus),
        .o_point    (point_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    t_cell        pending_cells[$];
    t_voxel_point expected_points[$];
    t_grid_cfg    grid_cfg = '{DIM_RESET, DIM_RESET, RES_RESET, '0, '0, '0};
    logic [9:0]   column_idx = '0;
    logic [9:0]   row_idx = '0;
    logic [9:0]   layer_idx = '0;
    int           n_errors = 0;
    int           cells_accepted = 0;
    int           cycle_count = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           stall_mode = 0;
    int           mode_left = 0;

    always #5 i_clk = ~i_clk;

    function automatic int eff_dim(logic [CFG_DIM_W-1:0] dim);
        if (dim == 0) return 1;
        if (dim > GRID_MAX) return GRID_MAX;
        return int'(dim);
    endfunction

    function automatic logic signed [POINT_W-1:0] voxel_centre(logic [9:0] idx,
                                                               logic signed [ORIGIN_W-1:0] origin);
        longint span;
        span = (longint'(grid_cfg.resolution) * (2 * longint'(idx) + 1)) >> 1;
        return POINT_W'(span + longint'(origin));
    endfunction

    function automatic void predict_cell(logic signed [OCC_W-1:0] occupancy, logic last_cell);
        t_voxel_point pt;
        logic         occupied;
        occupied = (occupancy == OCCUPIED_CODE);
        if (occupied || last_cell) begin
            pt.x = occupied ? voxel_centre(column_idx, grid_cfg.origin_x) : '0;
            pt.y = occupied ? voxel_centre(row_idx, grid_cfg.origin_y) : '0;
            pt.z = occupied ? voxel_centre(layer_idx, grid_cfg.origin_z) : '0;
            pt.point_valid = occupied;
            pt.grid_end = last_cell;
            expected_points.push_back(pt);
        end
        if (last_cell) begin
            column_idx = '0;
            row_idx = '0;
            layer_idx = '0;
        end else if (int'(column_idx) + 1 >= eff_dim(grid_cfg.grid_width)) begin
            column_idx = '0;
            if (int'(row_idx) + 1 >= eff_dim(grid_cfg.grid_depth)) begin
                row_idx = '0;
                if (int'(layer_idx) + 1 < GRID_MAX) layer_idx++;
            end else begin
                row_idx++;
            end
        end else begin
            column_idx++;
        end
    endfunction

    function automatic void compare_field(string field, logic [POINT_W-1:0] want,
                                          logic [POINT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", field, want, got);
            n_errors++;
        end
    endfunction

    function automatic void check_point();
        t_voxel_point want;
        if (expected_points.size() == 0) begin
            $error("point item with no cell behind it: x=%0h y=%0h z=%0h end=%0b",
                   point_bus.point_x, point_bus.point_y, point_bus.point_z,
                   point_bus.grid_end);
            n_errors++;
        end else begin
            want = expected_points.pop_front();
            compare_field("point_x", want.x, point_bus.point_x);
            compare_field("point_y", want.y, point_bus.point_y);
            compare_field("point_z", want.z, point_bus.point_z);
            compare_field("point_valid", want.point_valid, point_bus.point_valid);
            compare_field("grid_end", want.grid_end, point_bus.grid_end);
        end
    endfunction

    function automatic logic signed [OCC_W-1:0] pick_occupancy(int occupied_pct);
        logic signed [OCC_W-1:0] near_codes[7] = '{8'sd99, 8'sd101, 8'shE4, 8'sh9C, 8'sd0,
                                                   8'sh80, 8'sh7F};
        if ($urandom_range(0, 99) < occupied_pct) return OCCUPIED_CODE;
        if ($urandom_range(0, 3) == 0) return near_codes[$urandom_range(0, 6)];
        return OCC_W'($urandom);
    endfunction

    function automatic logic signed [ORIGIN_W-1:0] random_origin();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            default: return ORIGIN_W'($urandom);
        endcase
    endfunction

    function automatic t_grid_cfg random_grid_cfg();
        t_grid_cfg c;
        c.grid_width = ($urandom_range(0, 9) == 0) ? '0 : CFG_DIM_W'($urandom_range(1, 8));
        c.grid_depth = ($urandom_range(0, 9) == 0) ? '0 : CFG_DIM_W'($urandom_range(1, 5));
        case ($urandom_range(0, 5))
            0: c.resolution = '0;
            1: c.resolution = '1;
            2: c.resolution = RES_RESET;
            default: c.resolution = RES_W'($urandom);
        endcase
        c.origin_x = random_origin();
        c.origin_y = random_origin();
        c.origin_z = random_origin();
        return c;
    endfunction

    function automatic void queue_cell(logic signed [OCC_W-1:0] occupancy, logic last_cell);
        t_cell c;
        c.occupancy = occupancy;
        c.last_cell = last_cell;
        pending_cells.push_back(c);
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cells.size() != 0 || cell_bus.valid || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_grid_cfg(t_grid_cfg c);
        logic [CFG_DATA_W-1:0] data;
        @(posedge i_clk);
        for (int r = CFG_GRID_WIDTH; r <= CFG_ORIGIN_Z; r++) begin
            case (t_cfg_reg'(r))
                CFG_GRID_WIDTH: data = CFG_DATA_W'(c.grid_width);
                CFG_GRID_DEPTH: data = CFG_DATA_W'(c.grid_depth);
                CFG_RESOLUTION: data = CFG_DATA_W'(c.resolution);
                CFG_ORIGIN_X:   data = CFG_DATA_W'(c.origin_x);
                CFG_ORIGIN_Y:   data = CFG_DATA_W'(c.origin_y);
                default:        data = CFG_DATA_W'(c.origin_z);
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_index <= t_cfg_reg'(r);
            i_cfg_data <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        grid_cfg = c;
    endtask

    // Long grids run the counters up to the dimension limit; the cells near it are occupied.
    task automatic run_long_grid(t_grid_cfg c);
        wait_idle();
        load_grid_cfg(c);
        for (int i = 0; i < LONG_CELLS; i++) begin
            queue_cell((i >= GRID_MAX - 4) ? OCCUPIED_CODE : pick_occupancy(15),
                       i == LONG_CELLS - 1);
        end
    endtask

    always @(posedge i_clk) begin
        t_cell next_cell;
        if (!i_rst_n) begin
            cell_bus.valid <= 1'b0;
            cell_bus.occupancy <= '0;
            cell_bus.last_cell <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else if (!cell_bus.valid || cell_bus.ready) begin
            if (gap_left > 0 || pending_cells.size() == 0) begin
                if (gap_left > 0) gap_left--;
                cell_bus.valid <= 1'b0;
            end else begin
                next_cell = pending_cells.pop_front();
                cell_bus.valid <= 1'b1;
                cell_bus.occupancy <= next_cell.occupancy;
                cell_bus.last_cell <= next_cell.last_cell;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            point_bus.ready <= 1'b0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && cells_accepted >= HOLD_AT_CELL) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(4, 60);
                end
                mode_left--;
                case (stall_mode)
                    0, 1: rdy = 1'b1;
                    2: rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            point_bus.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cell_bus.valid && cell_bus.ready) begin
                predict_cell(cell_bus.occupancy, cell_bus.last_cell);
                cells_accepted <= cells_accepted + 1;
            end
            if (point_bus.valid && point_bus.ready) check_point();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_grid_cfg cfg_next;
        int        small_total;
        int        cells;
        int        shape;
        int        last_at;
        int        pause_at;
        int        occ_pct;
        cell_bus.valid = 1'b0;
        cell_bus.occupancy = '0;
        cell_bus.last_cell = 1'b0;
        point_bus.ready = 1'b0;
        small_total = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one cell per layer, so every cell not flagged last moves the layer counter.
        queue_cell(8'sh80, 1'b0);
        queue_cell(8'sh7F, 1'b0);
        queue_cell(8'sd0, 1'b0);
        queue_cell(8'sd99, 1'b0);
        queue_cell(8'sd101, 1'b0);
        queue_cell(8'shE4, 1'b0);
        queue_cell(OCCUPIED_CODE, 1'b0);
        queue_cell(OCCUPIED_CODE, 1'b1);
        queue_cell(8'sd50, 1'b1);
        queue_cell(OCCUPIED_CODE, 1'b0);
        queue_cell(OCCUPIED_CODE, 1'b0);

        // Odd resolution and extreme origins across two full layers and a bit.
        wait_idle();
        load_grid_cfg('{11'd3, 11'd2, 24'h01_8001, -32'sh0001_8000, 32'sh7FFF_FFFF,
                        32'sh8000_0000});
        for (int i = 0; i < 14; i++) queue_cell(OCCUPIED_CODE, i == 13);

        while (small_total < SMALL_CELLS) begin
            wait_idle();
            cfg_next = random_grid_cfg();
            load_grid_cfg(cfg_next);
            cells = eff_dim(cfg_next.grid_width) * eff_dim(cfg_next.grid_depth)
                    * $urandom_range(1, 3);
            shape = $urandom_range(0, 19);
            if (shape < 14) last_at = cells - 1;
            else if (shape < 17) last_at = $urandom_range(0, cells - 1);
            else last_at = -1;
            pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cells) : -1;
            occ_pct = $urandom_range(10, 90);
            for (int i = 0; i < cells && (last_at < 0 || i <= last_at); i++) begin
                if (i == pause_at) wait_idle();
                queue_cell(pick_occupancy(occ_pct), i == last_at);
                small_total++;
            end
        end

        run_long_grid('{11'd2047, 11'd1, 24'hFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        32'sh7FFF_FFFF});
        run_long_grid('{11'd1, 11'd2047, 24'h00_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh8000_0000});
        run_long_grid('{11'd0, 11'd0, 24'h00_A5A5, 32'sh1234_5678, -32'sh0000_0001,
                        -32'sh0123_4567});

        wait_idle();
        if (expected_points.size() != 0) begin
            $error("%0d expected point items never arrived", expected_points.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
